// ===== rtl/core/rrr_block_offset_rank_select_macros.svh =====
// Assertion helpers for the checker file rbors_chk.sv.
`ifndef RRR_BLOCK_OFFSET_RANK_SELECT_MACROS_SVH
`define RRR_BLOCK_OFFSET_RANK_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBORS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBORS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rbors_pkg.sv =====
package rbors_pkg;

  // Field widths of the request and result beats
  localparam int OP_W   = 2;
  localparam int BLK_W  = 15;
  localparam int CLS_W  = 4;
  localparam int OFF_W  = 13;
  localparam int IDX_W  = 4;
  localparam int TGT_W  = 4;
  localparam int ANS_W  = 4;
  localparam int OWID_W = 4;

  // Internal widths cover block sizes up to 31 bits
  localparam int MAX_N  = 32;
  localparam int MAX_K  = 16;
  localparam int BIN_W  = 32;
  localparam int CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ENCODE = 2'd0,
    OP_RANK   = 2'd1,
    OP_SEL1   = 2'd2,
    OP_SEL0   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef logic [MAX_K-1:0][BIN_W-1:0]  binom_row_t;
  typedef logic [MAX_N-1:0][MAX_K-1:0][BIN_W-1:0] binom_tab_t;
  typedef logic [MAX_K-1:0][OWID_W-1:0] width_row_t;
  typedef logic [MAX_N-1:0][MAX_K-1:0][OWID_W-1:0] width_tab_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] blk;
    logic [CLS_W-1:0] cls;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TGT_W-1:0] tgt;
  } req_t;

  // Context carried down the bit-step pipeline
  typedef struct packed {
    op_t               op;
    logic [BLK_W-1:0]  blk;
    logic [CLS_W-1:0]  cls;
    logic [CNT_W-1:0]  idx_last;
    logic [TGT_W-1:0]  tgt;
    logic              range_err;
    logic [OWID_W-1:0] owidth;
    logic [OFF_W-1:0]  rem;      // decode remainder
    logic [CLS_W-1:0]  r_dec;    // ones still to place when decoding
    logic [CLS_W-1:0]  r_enc;    // ones still to weigh when encoding
    logic [OFF_W-1:0]  acc;      // encode sum, low bits only
    logic [CNT_W-1:0]  ones;     // running ones of the decoded block
    logic [CNT_W-1:0]  pop;      // running popcount of the raw block
    logic              found;
    logic [ANS_W-1:0]  ans;
  } ctx_t;

  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  offset_out;
    logic [ANS_W-1:0]  answer;
    logic [OWID_W-1:0] offset_width;
  } res_t;

  // Pascal's triangle, C(n, k) for n < 32 and k < 16
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n < MAX_N; n++) begin
      for (int k = 0; k < MAX_K; k++) begin
        if (k == 0) begin
          t[n][k] = BIN_W'(1);
        end else if (n == 0) begin
          t[n][k] = '0;
        end else begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  // Offset field width: ceil(log2(count)), at least 1, kept to 4 bits
  function automatic logic [OWID_W-1:0] width_of(logic [BIN_W-1:0] count);
    int w;
    w = 0;
    for (int i = 0; i < BIN_W; i++) begin
      if ((64'd1 << w) < {32'd0, count}) w++;
    end
    if (w < 1) w = 1;
    return OWID_W'(w);
  endfunction

  function automatic width_tab_t build_width();
    width_tab_t t;
    t = '0;
    for (int n = 0; n < MAX_N; n++) begin
      for (int k = 0; k < MAX_K; k++) begin
        t[n][k] = width_of(BINOM[n][k]);
      end
    end
    return t;
  endfunction

  localparam width_tab_t OWIDTH = build_width();

endpackage

// ===== rtl/core/rbors_in_if.sv =====
interface rbors_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [14:0] raw_block;
  logic [3:0]  ones_class;
  logic [12:0] block_offset;
  logic [3:0]  bit_index;
  logic [3:0]  target_count;

  modport source (
    output valid, opcode, raw_block, ones_class, block_offset, bit_index, target_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, raw_block, ones_class, block_offset, bit_index, target_count,
    output ready
  );
endinterface

// ===== rtl/core/rbors_out_if.sv =====
interface rbors_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] offset_out;
  logic [3:0]  answer;
  logic [3:0]  offset_width;

  modport source (
    output valid, status, offset_out, answer, offset_width,
    input  ready
  );
  modport sink (
    input  valid, status, offset_out, answer, offset_width,
    output ready
  );
endinterface

// ===== rtl/core/rbors_front.sv =====
module rbors_front #(
  parameter int BLOCK_BITS = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  rbors_pkg::req_t req,
  output logic          ctx_valid,
  input  logic          ctx_ready,
  output rbors_pkg::ctx_t ctx
);
  import rbors_pkg::*;

  localparam binom_row_t       TOTAL_ROW = BINOM[BLOCK_BITS];
  localparam width_row_t       WID_ROW   = OWIDTH[BLOCK_BITS];
  localparam logic [BLK_W-1:0] BLK_MASK  = BLK_W'((33'd1 << BLOCK_BITS) - 33'd1);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(BLOCK_BITS - 1);
  localparam logic [CNT_W-1:0] NBITS     = CNT_W'(BLOCK_BITS);

  logic             valid_r;
  req_t             req_r;
  logic [BIN_W-1:0] total;
  logic [CNT_W-1:0] idx_ext;

  // Input register
  assign req_ready = !valid_r || ctx_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
    end
  end

  // Class lookups and the starting context
  assign total   = TOTAL_ROW[req_r.cls];
  assign idx_ext = {1'b0, req_r.idx};

  always_comb begin
    ctx           = '0;
    ctx.op        = req_r.op;
    ctx.blk       = req_r.blk & BLK_MASK;
    ctx.cls       = req_r.cls;
    ctx.idx_last  = (idx_ext >= NBITS) ? LAST_BIT : idx_ext;
    ctx.tgt       = req_r.tgt;
    ctx.range_err = {{(BIN_W-OFF_W){1'b0}}, req_r.off} >= total;
    ctx.owidth    = WID_ROW[req_r.cls];
    ctx.rem       = req_r.off;
    ctx.r_dec     = req_r.cls;
    ctx.r_enc     = req_r.cls;
  end

  assign ctx_valid = valid_r;

endmodule

// ===== rtl/core/rbors_step.sv =====
module rbors_step #(
  parameter int BLOCK_BITS = 15,
  parameter int POS        = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rbors_pkg::ctx_t in_ctx,
  output logic            out_valid,
  input  logic            out_ready,
  output rbors_pkg::ctx_t out_ctx
);
  import rbors_pkg::*;

  // Weight of this bit position: C(BLOCK_BITS-1-POS, r)
  localparam binom_row_t       ROW      = BINOM[BLOCK_BITS-1-POS];
  localparam int               SHIFT    = BLOCK_BITS - 1 - POS;
  localparam logic [ANS_W-1:0] POS_ANS  = ANS_W'(POS);
  localparam logic [CNT_W-1:0] POS_CNT  = CNT_W'(POS);
  localparam logic [CNT_W-1:0] SEEN_CNT = CNT_W'(POS + 1);

  logic             valid_r;
  ctx_t             ctx_r;
  ctx_t             ctx_nxt;
  logic [BIN_W-1:0] c_dec;
  logic [BIN_W-1:0] c_enc;
  logic             take;
  logic [BLK_W-1:0] blk_sh;
  logic             blk_bit;
  logic [CNT_W-1:0] sel_cnt;

  assign c_dec   = ROW[in_ctx.r_dec];
  assign c_enc   = ROW[in_ctx.r_enc];
  assign take    = (in_ctx.r_dec != '0) &&
                   ({{(BIN_W-OFF_W){1'b0}}, in_ctx.rem} >= c_dec);
  assign blk_sh  = in_ctx.blk >> SHIFT;
  assign blk_bit = blk_sh[0];

  // One decode step, one encode step and the query update for this bit
  always_comb begin
    ctx_nxt = in_ctx;
    if (take) begin
      ctx_nxt.rem   = in_ctx.rem - c_dec[OFF_W-1:0];
      ctx_nxt.r_dec = in_ctx.r_dec - 1'b1;
      ctx_nxt.ones  = in_ctx.ones + 1'b1;
    end
    sel_cnt = (in_ctx.op == OP_SEL1) ? ctx_nxt.ones : (SEEN_CNT - ctx_nxt.ones);
    case (in_ctx.op)
      OP_RANK: begin
        if (in_ctx.idx_last == POS_CNT) ctx_nxt.ans = ctx_nxt.ones[ANS_W-1:0];
      end
      OP_SEL1, OP_SEL0: begin
        if (!in_ctx.found && sel_cnt == {1'b0, in_ctx.tgt}) begin
          ctx_nxt.ans   = POS_ANS;
          ctx_nxt.found = 1'b1;
        end
      end
      default: ;
    endcase
    if (blk_bit) begin
      ctx_nxt.pop = in_ctx.pop + 1'b1;
      if (in_ctx.r_enc != '0) begin
        ctx_nxt.acc   = in_ctx.acc + c_enc[OFF_W-1:0];
        ctx_nxt.r_enc = in_ctx.r_enc - 1'b1;
      end
    end
  end

  // Stage register
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctx_r <= ctx_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_ctx   = ctx_r;

endmodule

// ===== rtl/core/rrr_block_offset_rank_select.sv =====
// RRR block codec: offset encode, rank and select within one block.
// Pipeline: input register, one stage per block bit, result register.
// Throughput: one beat per cycle when the result side is not stalled;
// each stage does one binomial compare/subtract and one binomial add.
// Reset: synchronous active-low rst_n clears all stage valid bits; no other state.
module rrr_block_offset_rank_select #(
  parameter int BLOCK_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  rbors_in_if.sink           in_bus,
  rbors_out_if.source        out_bus
);
  import rbors_pkg::*;

  logic [BLOCK_BITS:0] v_chain;
  logic [BLOCK_BITS:0] r_chain;
  ctx_t                ctx_chain [BLOCK_BITS+1];
  req_t                req;
  ctx_t                last;
  res_t                res_nxt;
  res_t                res_r;
  logic                out_valid_r;
  logic                out_take;

  assign req.op  = op_t'(in_bus.opcode);
  assign req.blk = in_bus.raw_block;
  assign req.cls = in_bus.ones_class;
  assign req.off = in_bus.block_offset;
  assign req.idx = in_bus.bit_index;
  assign req.tgt = in_bus.target_count;

  rbors_front #(.BLOCK_BITS(BLOCK_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_bus.valid),
    .req_ready (in_bus.ready),
    .req       (req),
    .ctx_valid (v_chain[0]),
    .ctx_ready (r_chain[0]),
    .ctx       (ctx_chain[0])
  );

  // One stage per block bit, MSB first
  for (genvar k = 0; k < BLOCK_BITS; k++) begin : g_step
    rbors_step #(.BLOCK_BITS(BLOCK_BITS), .POS(k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_chain[k]),
      .in_ready  (r_chain[k]),
      .in_ctx    (ctx_chain[k]),
      .out_valid (v_chain[k+1]),
      .out_ready (r_chain[k+1]),
      .out_ctx   (ctx_chain[k+1])
    );
  end

  // Result formatting
  assign last = ctx_chain[BLOCK_BITS];

  always_comb begin
    res_nxt              = '0;
    res_nxt.offset_width = last.owidth;
    if (last.op == OP_ENCODE) begin
      if (last.pop != {1'b0, last.cls}) begin
        res_nxt.status = ST_MISMATCH;
      end else begin
        res_nxt.status     = ST_OK;
        res_nxt.offset_out = last.acc;
      end
    end else if (last.range_err) begin
      res_nxt.status = ST_RANGE;
    end else if (last.op == OP_RANK || last.found) begin
      res_nxt.status = ST_OK;
      res_nxt.answer = last.ans;
    end else begin
      res_nxt.status = ST_NOTFOUND;
    end
  end

  // Result register
  assign r_chain[BLOCK_BITS] = !out_valid_r || out_bus.ready;
  assign out_take            = v_chain[BLOCK_BITS] && r_chain[BLOCK_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_chain[BLOCK_BITS]) begin
      out_valid_r <= v_chain[BLOCK_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = res_r.status;
  assign out_bus.offset_out   = res_r.offset_out;
  assign out_bus.answer       = res_r.answer;
  assign out_bus.offset_width = res_r.offset_width;

endmodule

// ===== rtl/core/rbors_chk.sv =====
`include "rrr_block_offset_rank_select_macros.svh"

module rbors_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [12:0] out_offset_out,
  input logic [3:0]  out_answer,
  input logic [3:0]  out_offset_width
);
  import rbors_pkg::*;

  logic        out_stall;
  logic        out_fail;
  logic        out_data;
  logic [22:0] out_beat;

  // Shorthand for the result side
  assign out_stall = out_valid && !out_ready;
  assign out_fail  = out_valid && (out_status != ST_OK);
  assign out_data  = |{out_answer, out_offset_out};
  assign out_beat  = {out_status, out_offset_out, out_answer, out_offset_width};

  // A stalled result beat holds
  `RBORS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_beat), "beat changed")

  // The input side only backs up when the result side is stalled
  `RBORS_ASSERT_IMP(a_in_bp, clk, rst_n, !in_ready, out_stall, "input stalled while output free")

  // A failed request carries neither an offset nor an answer
  `RBORS_ASSERT_IMP(a_fail_zero, clk, rst_n, out_fail, !out_data, "failed beat has data")

  // Offset width is never zero
  `RBORS_ASSERT_IMP(a_owidth_nz, clk, rst_n, out_valid, out_offset_width != '0, "zero offset width")

endmodule

bind rrr_block_offset_rank_select rbors_chk u_rbors_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_status       (out_bus.status),
  .out_offset_out   (out_bus.offset_out),
  .out_answer       (out_bus.answer),
  .out_offset_width (out_bus.offset_width)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import rbors_pkg::*;

  localparam int BLOCK_BITS  = 15;
  localparam int LATENCY     = BLOCK_BITS + 2;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;

  rbors_in_if  in_bus();
  rbors_out_if out_bus();

  rrr_block_offset_rank_select #(
    .BLOCK_BITS(BLOCK_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Expected results, oldest first
  res_t pending_res_q[$];
  int   fail_cnt;
  int   cycle_cnt;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_ticket;
  int   hold_seen;
  int   hold_left;

  // Binomial coefficient; zero when k exceeds n
  function automatic longint unsigned binom(int n, int k);
    longint unsigned r;
    r = 1;
    if (k > n || k < 0) return 0;
    for (int i = 0; i < k; i++) r = r * longint'(n - i) / longint'(i + 1);
    return r;
  endfunction

  // Expected result of one request
  function automatic res_t predict_result(req_t rq);
    res_t             rs;
    longint unsigned  total, acc, rem, c;
    logic [BLK_W-1:0] dec;
    int               r, ones, pop, last, cnt, w;
    bit               found;
    rs = '0;
    total = binom(BLOCK_BITS, rq.cls);
    if (rq.op == OP_ENCODE) begin
      pop = $countones(rq.blk);
      if (pop != rq.cls) begin
        rs.status = ST_MISMATCH;
      end else begin
        // combinatorial number system, MSB first
        r = rq.cls;
        acc = 0;
        for (int i = 0; i < BLOCK_BITS && r > 0; i++) begin
          if (rq.blk[BLOCK_BITS-1-i]) begin
            acc += binom(BLOCK_BITS - 1 - i, r);
            r--;
          end
        end
        rs.offset_out = acc[OFF_W-1:0];
      end
    end else if (rq.off >= total) begin
      rs.status = ST_RANGE;
    end else begin
      // rebuild the block from class and offset
      rem = rq.off;
      r = rq.cls;
      dec = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
        c = binom(BLOCK_BITS - 1 - i, r);
        if (r > 0 && rem >= c) begin
          rem -= c;
          r--;
          dec[BLOCK_BITS-1-i] = 1'b1;
        end
      end
      ones = 0;
      if (rq.op == OP_RANK) begin
        last = (rq.idx >= BLOCK_BITS) ? BLOCK_BITS - 1 : int'(rq.idx);
        for (int i = 0; i <= last; i++) ones += dec[BLOCK_BITS-1-i];
        rs.answer = ANS_W'(ones);
      end else begin
        found = 1'b0;
        for (int i = 0; i < BLOCK_BITS && !found; i++) begin
          ones += dec[BLOCK_BITS-1-i];
          cnt = (rq.op == OP_SEL1) ? ones : i + 1 - ones;
          if (cnt == rq.tgt) begin
            rs.answer = ANS_W'(i);
            found = 1'b1;
          end
        end
        if (!found) rs.status = ST_NOTFOUND;
      end
    end
    // offset field width for the class
    w = 0;
    while (w < 63 && (64'd1 << w) < total) w++;
    if (w < 1) w = 1;
    rs.offset_width = OWID_W'(w);
    return rs;
  endfunction

  function automatic req_t make_req(op_t op, int blk, int cls, int off, int idx, int tgt);
    req_t rq;
    rq.op  = op;
    rq.blk = BLK_W'(blk);
    rq.cls = CLS_W'(cls);
    rq.off = OFF_W'(off);
    rq.idx = IDX_W'(idx);
    rq.tgt = TGT_W'(tgt);
    return rq;
  endfunction

  // Random block holding exactly k ones
  function automatic logic [BLK_W-1:0] block_with_ones(int k);
    logic [BLK_W-1:0] b;
    int               placed, p;
    b = '0;
    placed = 0;
    while (placed < k) begin
      p = $urandom_range(BLK_W - 1);
      if (!b[p]) begin
        b[p] = 1'b1;
        placed++;
      end
    end
    return b;
  endfunction

  // Mostly well-formed requests, the rest raw noise
  function automatic req_t random_req();
    req_t            rq;
    longint unsigned total;
    rq.op  = op_t'($urandom_range(3));
    rq.blk = BLK_W'($urandom);
    rq.cls = CLS_W'($urandom_range(15));
    rq.off = OFF_W'($urandom);
    rq.idx = IDX_W'($urandom_range(15));
    rq.tgt = TGT_W'($urandom_range(15));
    total = binom(BLOCK_BITS, rq.cls);
    if ($urandom_range(9) < 8) begin
      if (rq.op == OP_ENCODE) rq.blk = block_with_ones(rq.cls);
      else rq.off = OFF_W'($urandom_range(int'(total) - 1));
    end
    return rq;
  endfunction

  // Offer one beat, with an optional random gap ahead of it
  task automatic send_item(input req_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= rq.op;
    in_bus.raw_block    <= rq.blk;
    in_bus.ones_class   <= rq.cls;
    in_bus.block_offset <= rq.off;
    in_bus.bit_index    <= rq.idx;
    in_bus.target_count <= rq.tgt;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_res_q.push_back(predict_result(rq));
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_encode_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(make_req(OP_ENCODE, 15'h0000, 0, 0, 0, 0));
    send_item(make_req(OP_ENCODE, 15'h7fff, 15, 0, 0, 0));
    send_item(make_req(OP_ENCODE, 15'h7fff, 14, 0, 0, 0));   // popcount mismatch
    send_item(make_req(OP_ENCODE, 15'h7f00, 7, 0, 0, 0));    // top offset of class 7, one of the widest
    send_item(make_req(OP_ENCODE, 15'h00ff, 8, 0, 0, 0));
    send_item(make_req(OP_ENCODE, 15'h5555, 8, 0, 0, 0));
    send_item(make_req(OP_ENCODE, 15'h0001, 1, 0, 0, 0));
    send_item(make_req(OP_ENCODE, 15'h4000, 0, 0, 0, 0));    // popcount mismatch
    wait_drain();
  endtask

  task automatic test_rank_cases();
    send_item(make_req(OP_RANK, 0, 7, 0, 0, 0));
    send_item(make_req(OP_RANK, 0, 7, 6434, 14, 0));         // last offset of class
    send_item(make_req(OP_RANK, 0, 7, 6435, 3, 0));          // offset out of range
    send_item(make_req(OP_RANK, 0, 0, 8191, 0, 0));          // offset out of range
    send_item(make_req(OP_RANK, 0, 15, 0, 15, 0));           // index saturates
    send_item(make_req(OP_RANK, 0, 4, 100, 7, 0));
    wait_drain();
  endtask

  task automatic test_select_cases();
    send_item(make_req(OP_SEL1, 0, 0, 0, 0, 0));             // zero target hit at once
    send_item(make_req(OP_SEL1, 0, 3, 5, 0, 15));            // target never reached
    send_item(make_req(OP_SEL1, 0, 15, 0, 0, 15));
    send_item(make_req(OP_SEL1, 0, 1, 1, 0, 1));
    send_item(make_req(OP_SEL0, 0, 0, 0, 0, 15));
    send_item(make_req(OP_SEL0, 0, 1, 0, 0, 15));            // target never reached
    send_item(make_req(OP_SEL0, 0, 15, 0, 0, 0));
    send_item(make_req(OP_SEL0, 0, 8, 6434, 0, 7));
    send_item(make_req(OP_SEL0, 0, 8, 6435, 0, 7));          // offset out of range
    wait_drain();
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct_v);
    send_idle_pct = idle_pct;
    stall_pct = stall_pct_v;
    for (int n = 0; n < count; n++) send_item(random_req());
    wait_drain();
  endtask

  task automatic test_random_phases();
    run_random(210, 0, 0);
    run_random(210, 45, 0);
    run_random(210, 0, 45);
    run_random(210, 30, 30);
  endtask

  // Long receiver hold-off fills the pipe, then the sender waits for it to empty
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_ticket <= hold_ticket + 1;
    for (int n = 0; n < 60; n++) send_item(random_req());
    wait_drain();
    for (int n = 0; n < 20; n++) send_item(random_req());
    wait_drain();
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side ready, with random stalls and an on-demand long hold-off
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_res_q.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_cnt++;
      end else begin
        want = pending_res_q.pop_front();
        if (out_bus.status !== want.status) begin
          $error("field status expected %0d actual %0d", want.status, out_bus.status);
          fail_cnt++;
        end
        if (out_bus.offset_out !== want.offset_out) begin
          $error("field offset_out expected %0d actual %0d", want.offset_out,
                 out_bus.offset_out);
          fail_cnt++;
        end
        if (out_bus.answer !== want.answer) begin
          $error("field answer expected %0d actual %0d", want.answer, out_bus.answer);
          fail_cnt++;
        end
        if (out_bus.offset_width !== want.offset_width) begin
          $error("field offset_width expected %0d actual %0d", want.offset_width,
                 out_bus.offset_width);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    fail_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_ticket = 0;
    hold_seen = 0;
    hold_left = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = '0;
    in_bus.raw_block = '0;
    in_bus.ones_class = '0;
    in_bus.block_offset = '0;
    in_bus.bit_index = '0;
    in_bus.target_count = '0;
    out_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_encode_cases();
    test_rank_cases();
    test_select_cases();
    test_random_phases();
    test_backpressure();

    wait_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
